// ===== rtl/core/wxdev_pkg.sv =====
// Package: letter tables, code points and shared types for the WX to Devanagari converter.
`timescale 1ns / 1ps
package wxdev_pkg;

   localparam logic [7:0] LETTER_BASE = 8'd65;
   localparam logic [7:0] CH_NUKTA    = 8'h5A; // 'Z'
   localparam logic [7:0] CH_A        = 8'h61; // 'a'
   localparam logic [7:0] CH_O        = 8'h6F; // 'o'
   localparam logic [7:0] CH_Y        = 8'h59; // 'Y'
   localparam logic [7:0] CH_AT       = 8'h40; // '@'
   localparam logic [7:0] CH_DASH     = 8'h2D; // '-'

   localparam logic [15:0] CP_HALANT  = 16'h094D;
   localparam logic [15:0] CP_CANDRA_O = 16'h0949;
   localparam logic [15:0] CP_NUKTA   = 16'h093C;

   localparam int QUEUE_DEPTH = 2;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CLS_NONE  = 2'd0,
      CLS_CONS  = 2'd1,
      CLS_VOWEL = 2'd2
   } class_type;

   // One decided step: up to three code points, or a raw byte, plus flags.
   typedef struct packed {
      logic        raw;
      logic [7:0]  raw_byte;
      logic [15:0] cp0;
      logic [15:0] cp1;
      logic [15:0] cp2;
      logic        is_last;
      logic        text_end;
   } job_type;

   function automatic logic is_letter(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
   endfunction

   function automatic logic in_run(input logic [7:0] b);
      return is_letter(b) || (b >= 8'h30 && b <= 8'h39) || b == CH_DASH;
   endfunction

   function automatic logic [15:0] glyph_cp(input logic [7:0] b);
      logic [15:0] r;
      r = 16'h0000;
      case (b)
         8'h41: r = 16'h0906; 8'h42: r = 16'h092D; 8'h43: r = 16'h091B;
         8'h44: r = 16'h0922; 8'h45: r = 16'h0910; 8'h46: r = 16'h091E;
         8'h47: r = 16'h0918; 8'h48: r = 16'h0903; 8'h49: r = 16'h0908;
         8'h4A: r = 16'h091D; 8'h4B: r = 16'h0916; 8'h4D: r = 16'h0902;
         8'h4E: r = 16'h0923; 8'h4F: r = 16'h0914; 8'h50: r = 16'h092B;
         8'h51: r = 16'h0960; 8'h52: r = 16'h0937; 8'h53: r = 16'h0936;
         8'h54: r = 16'h0920; 8'h55: r = 16'h090A; 8'h57: r = 16'h0925;
         8'h58: r = 16'h0927; 8'h5A: r = 16'h093C;
         8'h61: r = 16'h0905; 8'h62: r = 16'h092C; 8'h63: r = 16'h091A;
         8'h64: r = 16'h0921; 8'h65: r = 16'h090F; 8'h66: r = 16'h0919;
         8'h67: r = 16'h0917; 8'h68: r = 16'h0939; 8'h69: r = 16'h0907;
         8'h6A: r = 16'h091C; 8'h6B: r = 16'h0915; 8'h6C: r = 16'h0932;
         8'h6D: r = 16'h092E; 8'h6E: r = 16'h0928; 8'h6F: r = 16'h0913;
         8'h70: r = 16'h092A; 8'h71: r = 16'h090B; 8'h72: r = 16'h0930;
         8'h73: r = 16'h0938; 8'h74: r = 16'h091F; 8'h75: r = 16'h0909;
         8'h76: r = 16'h0935; 8'h77: r = 16'h0924; 8'h78: r = 16'h0926;
         8'h79: r = 16'h092F; 8'h7A: r = 16'h0901;
         default: r = 16'h0000;
      endcase
      return r;
   endfunction

   function automatic logic [15:0] sign_cp(input logic [7:0] b);
      logic [15:0] r;
      r = 16'h0000;
      case (b)
         8'h41: r = 16'h093E; 8'h45: r = 16'h0948; 8'h48: r = 16'h0903;
         8'h49: r = 16'h0940; 8'h4D: r = 16'h0902; 8'h4F: r = 16'h094C;
         8'h51: r = 16'h0944; 8'h55: r = 16'h0942; 8'h5A: r = 16'h093C;
         8'h65: r = 16'h0947; 8'h69: r = 16'h093F; 8'h6F: r = 16'h094B;
         8'h71: r = 16'h0943; 8'h75: r = 16'h0941; 8'h7A: r = 16'h0901;
         default: r = 16'h0000;
      endcase
      return r;
   endfunction

   function automatic class_type letter_class(input logic [7:0] b);
      class_type r;
      r = CLS_NONE;
      if (is_letter(b)) begin
         if (sign_cp(b) != 16'h0000 || b == CH_A) begin
            r = CLS_VOWEL;
         end else if (glyph_cp(b) != 16'h0000) begin
            r = CLS_CONS;
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/wx_to_devanagari_utf8.sv =====
// Top level: WX text to Devanagari UTF-8 converter.
`timescale 1ns / 1ps
// Takes one WX byte per transaction and returns its UTF-8 bytes, one per
// cycle while rsp_ready is high. A consonant waits in a two-byte window
// until the following bytes settle its form; req_in_last flushes the window
// and ends verbatim mode. The front end registers a byte into the window,
// then resolves one window step per cycle into a two-entry queue while it
// has room; it takes a new byte only once it is through with the last. The
// back end serializes each step at one byte per cycle while rsp_ready is
// high, up to nine bytes per step, through an output register. Throughput
// is set by output bytes; a stalled rsp_ready backs up the queue, then req_ready.
module wx_to_devanagari_utf8 import wxdev_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last,
   output logic       rsp_out_text_end
);

   logic    fj_valid, fj_ready, bj_valid, bj_ready;
   job_type fj, bj;

   wxdev_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_in_byte, .req_in_last,
      .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
   );

   wxdev_queue u_queue (
      .clock, .reset, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
      .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_job(bj)
   );

   wxdev_back u_back (
      .clock, .reset, .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
      .rsp_valid, .rsp_ready, .rsp_out_byte, .rsp_out_last, .rsp_out_text_end
   );

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_text_end |-> rsp_out_last)
      else $error("text end without last");

   a_raw_single: assert property (@(posedge clock) disable iff (reset)
      fj_valid && fj.raw |-> fj.cp0 == '0)
      else $error("raw job carries code point");

endmodule

// ===== rtl/core/wxdev_front.sv =====
// Front end: lookahead window, classification and step decisions.
`timescale 1ns / 1ps
module wxdev_front import wxdev_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       job_valid,
   input  logic       job_ready,
   output job_type    job
);

   // Window holds up to three bytes: two pending plus the one just taken.
   logic [7:0] win_ff [3];
   logic [7:0] win_in [3];
   logic [1:0] cnt_ff, cnt_in;
   logic       fin_ff, fin_in;
   logic       verb_ff, verb_in;
   logic       busy_ff, busy_in;   // window holds an item being resolved

   logic [7:0]  c, n1, n2;
   logic        stall;   // front byte needs more input
   logic [1:0]  pop;
   logic        step_fire;
   logic        step_out; // step produces bytes
   job_type     step_job;
   logic [1:0]  rem;
   logic        done;     // window drained for this item

   always_comb begin
      c = win_ff[0];
      n1 = win_ff[1];
      n2 = win_ff[2];
      stall = 1'b0;
      pop = 2'd1;
      verb_in = verb_ff;
      step_job = '0;
      step_job.cp0 = '0;
      step_out = 1'b1;
      if (verb_ff && in_run(c)) begin
         step_job.raw = 1'b1;
         step_job.raw_byte = c;
      end else begin
         verb_in = 1'b0;
         case (letter_class(c))
            CLS_VOWEL: step_job.cp0 = glyph_cp(c);
            CLS_CONS: begin
               step_job.cp0 = glyph_cp(c);
               if (cnt_ff < 2'd2 && !fin_ff) begin
                  stall = 1'b1;
               end else if (cnt_ff < 2'd2 || letter_class(n1) != CLS_VOWEL) begin
                  step_job.cp1 = CP_HALANT;
               end else if (n1 == CH_A) begin
                  pop = 2'd2;
               end else if (n1 == CH_NUKTA || n1 == CH_O) begin
                  if (cnt_ff < 2'd3 && !fin_ff) begin
                     stall = 1'b1;
                  end else if (n1 == CH_NUKTA) begin
                     step_job.cp1 = CP_NUKTA;
                     if (cnt_ff == 2'd3 && letter_class(n2) == CLS_VOWEL) begin
                        if (n2 != CH_A) step_job.cp2 = sign_cp(n2);
                        pop = 2'd3;
                     end else begin
                        step_job.cp2 = CP_HALANT;
                        pop = 2'd2;
                     end
                  end else if (cnt_ff == 2'd3 && n2 == CH_Y) begin
                     step_job.cp1 = CP_CANDRA_O;
                     pop = 2'd3;
                  end else begin
                     step_job.cp1 = sign_cp(n1);
                     pop = 2'd2;
                  end
               end else begin
                  step_job.cp1 = sign_cp(n1);
                  pop = 2'd2;
               end
            end
            default: begin
               step_job.raw = 1'b1;
               step_job.raw_byte = c;
               if (c == CH_AT) verb_in = 1'b1;
            end
         endcase
      end
      if (!step_job.raw && step_job.cp0 == '0 && step_job.cp1 == '0
          && step_job.cp2 == '0) begin
         step_out = 1'b0; // no bytes: nothing to queue
      end
      rem = cnt_ff - pop;
   end

   // Last-result flag: the item ends when window empties or the next front byte stalls.
   // The next step's stall is predicted here from the bytes left after this step.
   logic        la_stall;
   logic [7:0]  la_w0, la_w1;
   always_comb begin
      la_w0 = (pop == 2'd1) ? n1 : n2;
      la_w1 = n2;
      la_stall = 1'b1;
      if (rem != 2'd0) begin
         if ((verb_in && in_run(la_w0)) || letter_class(la_w0) != CLS_CONS || fin_ff) begin
            la_stall = 1'b0;
         end else if (rem >= 2'd2) begin
            if (!(letter_class(la_w1) == CLS_VOWEL && (la_w1 == CH_NUKTA || la_w1 == CH_O)))
               la_stall = 1'b0;
         end
      end
   end

   assign done = (rem == 2'd0) || la_stall;

   always_comb begin
      job = step_job;
      job.is_last = done;
      job.text_end = done && fin_ff;
   end

   // A step fires when busy, not stalled and, if it has output, accepted; jobs with no output still fire.
   assign job_valid = busy_ff && !stall && step_out;
   assign step_fire = busy_ff && !stall && (!step_out || job_ready);
   assign req_ready = !busy_ff;

   // When an item ends with no result at all (stall at entry), nothing is shown.
   always_comb begin
      win_in[0] = win_ff[0];
      win_in[1] = win_ff[1];
      win_in[2] = win_ff[2];
      cnt_in = cnt_ff;
      fin_in = fin_ff;
      busy_in = busy_ff;
      if (!busy_ff) begin
         if (req_valid) begin
            win_in[cnt_ff] = req_in_byte;
            cnt_in = cnt_ff + 2'd1;
            fin_in = req_in_last;
            busy_in = 1'b1;
         end
      end else if (stall) begin
         busy_in = 1'b0; // wait for more bytes
      end else if (step_fire) begin
         if (pop == 2'd1) begin
            win_in[0] = n1; win_in[1] = n2;
         end else if (pop == 2'd2) begin
            win_in[0] = n2;
         end
         cnt_in = rem;
         if (done) begin
            busy_in = 1'b0;
            if (fin_ff) cnt_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (reset) begin
         cnt_ff <= '0;
         fin_ff <= 1'b0;
         verb_ff <= 1'b0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         fin_ff <= fin_in;
         busy_ff <= busy_in;
         if (step_fire) verb_ff <= (done && fin_ff) ? 1'b0 : verb_in;
      end
   end

endmodule

// ===== rtl/core/wxdev_queue.sv =====
// Two-entry job queue between the front end and the byte serializer.
`timescale 1ns / 1ps
module wxdev_queue import wxdev_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   output logic    wr_ready,
   input  job_type wr_job,
   output logic    rd_valid,
   input  logic    rd_ready,
   output job_type rd_job
);

   job_type            mem_ff [QUEUE_DEPTH];
   logic               wp_ff, wp_in, rp_ff, rp_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic               wr_go, rd_go;

   assign wr_ready = cnt_ff != QCNT_W'(QUEUE_DEPTH);
   assign rd_valid = cnt_ff != '0;
   assign rd_job = mem_ff[rp_ff];
   assign wr_go = wr_valid && wr_ready;
   assign rd_go = rd_valid && rd_ready;

   always_comb begin
      wp_in = wr_go ? ~wp_ff : wp_ff;
      rp_in = rd_go ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + QCNT_W'(wr_go) - QCNT_W'(rd_go);
   end

   always_ff @(posedge clock) begin
      if (wr_go) mem_ff[wp_ff] <= wr_job;
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/core/wxdev_back.sv =====
// Back end: serializes each job to registered UTF-8 bytes, one per cycle unless stalled.
`timescale 1ns / 1ps
module wxdev_back import wxdev_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       job_valid,
   output logic       job_ready,
   input  job_type    job,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last,
   output logic       rsp_out_text_end
);

   // Flat list of up to nine bytes for the current job.
   logic [7:0] bytes [9];
   logic [3:0] nbytes;
   logic [3:0] idx_ff, idx_in;
   logic       oval_ff, oval_in;
   logic [7:0] obyte_ff, obyte_in;
   logic       olast_ff, olast_in, oend_ff, oend_in;
   logic       take, final_byte;
   logic [15:0] cps [3];
   logic [3:0]  n;

   always_comb begin
      cps[0] = job.cp0; cps[1] = job.cp1; cps[2] = job.cp2;
      for (int i = 0; i < 9; i++) bytes[i] = 8'h00;
      n = 4'd0;
      if (job.raw) begin
         bytes[0] = job.raw_byte;
         n = 4'd1;
      end else begin
         for (int k = 0; k < 3; k++) begin
            if (cps[k] != 16'h0000) begin
               bytes[n]        = 8'hE0;
               bytes[n + 4'd1] = 8'h80 | {2'b00, cps[k][11:6]};
               bytes[n + 4'd2] = 8'h80 | {2'b00, cps[k][5:0]};
               n = n + 4'd3;
            end
         end
      end
      nbytes = n;
   end

   assign take = job_valid && (!oval_ff || rsp_ready);
   assign final_byte = (idx_ff + 4'd1) >= nbytes;
   assign job_ready = take && final_byte;

   always_comb begin
      idx_in = idx_ff;
      oval_in = oval_ff && !rsp_ready;
      obyte_in = obyte_ff;
      olast_in = olast_ff;
      oend_in = oend_ff;
      if (take) begin
         oval_in = 1'b1;
         obyte_in = bytes[idx_ff];
         olast_in = final_byte && job.is_last;
         oend_in = final_byte && job.text_end;
         idx_in = final_byte ? 4'd0 : idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      obyte_ff <= obyte_in;
      olast_ff <= olast_in;
      oend_ff <= oend_in;
      if (reset) begin
         idx_ff <= '0;
         oval_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         oval_ff <= oval_in;
      end
   end

   assign rsp_valid = oval_ff;
   assign rsp_out_byte = obyte_ff;
   assign rsp_out_last = olast_ff;
   assign rsp_out_text_end = oend_ff;

endmodule

// ===== test/wx_to_devanagari_utf8_checker.sv =====
// Checker: predicts the UTF-8 byte stream from accepted WX bytes and compares results.
`timescale 1ns / 1ps
module wx_to_devanagari_utf8_checker import wxdev_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_out_last,
   input  logic       rsp_out_text_end,
   output int         fail_count,
   output int         bytes_owed
);

   typedef struct {
      logic [7:0] data;
      logic       last;
      logic       text_end;
   } utf8_byte_type;

   // index = byte - 'A'
   localparam logic [15:0] GLYPH [0:57] = '{
      16'h0906, 16'h092D, 16'h091B, 16'h0922, 16'h0910, 16'h091E, 16'h0918, 16'h0903,
      16'h0908, 16'h091D, 16'h0916, 16'h0000, 16'h0902, 16'h0923, 16'h0914, 16'h092B,
      16'h0960, 16'h0937, 16'h0936, 16'h0920, 16'h090A, 16'h0000, 16'h0925, 16'h0927,
      16'h0000, 16'h093C, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0905, 16'h092C, 16'h091A, 16'h0921, 16'h090F, 16'h0919, 16'h0917, 16'h0939,
      16'h0907, 16'h091C, 16'h0915, 16'h0932, 16'h092E, 16'h0928, 16'h0913, 16'h092A,
      16'h090B, 16'h0930, 16'h0938, 16'h091F, 16'h0909, 16'h0935, 16'h0924, 16'h0926,
      16'h092F, 16'h0901};
   localparam logic [15:0] VSIGN [0:57] = '{
      16'h093E, 16'h0000, 16'h0000, 16'h0000, 16'h0948, 16'h0000, 16'h0000, 16'h0903,
      16'h0940, 16'h0000, 16'h0000, 16'h0000, 16'h0902, 16'h0000, 16'h094C, 16'h0000,
      16'h0944, 16'h0000, 16'h0000, 16'h0000, 16'h0942, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h093C, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0947, 16'h0000, 16'h0000, 16'h0000,
      16'h093F, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h094B, 16'h0000,
      16'h0943, 16'h0000, 16'h0000, 16'h0000, 16'h0941, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0901};

   utf8_byte_type expected_bytes[$];
   logic [7:0] window[2];
   int         window_fill;
   logic       verbatim;
   logic [7:0] step_bytes[$];

   function automatic logic alpha(input logic [7:0] b);
      return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
   endfunction

   function automatic class_type kind_of(input logic [7:0] b);
      if (!alpha(b)) return CLS_NONE;
      if (VSIGN[b - LETTER_BASE] != 0 || b == CH_A) return CLS_VOWEL;
      if (GLYPH[b - LETTER_BASE] != 0) return CLS_CONS;
      return CLS_NONE;
   endfunction

   task automatic emit_cp(input logic [15:0] cp);
      if (cp != 0) begin
         step_bytes.push_back(8'hE0);
         step_bytes.push_back(8'h80 | 8'((cp >> 6) & 16'h003F));
         step_bytes.push_back(8'h80 | 8'(cp & 16'h003F));
      end
   endtask

   task automatic convert_byte(input logic [7:0] b, input logic fin);
      logic [7:0] w[3];
      logic [7:0] c, n1, n2;
      logic [15:0] g;
      int cnt, pop;
      utf8_byte_type e;
      w[0] = window[0];
      w[1] = window[1];
      w[2] = 8'h00;
      cnt = window_fill;
      w[cnt] = b;
      cnt++;
      step_bytes.delete();
      while (cnt > 0) begin
         c = w[0];
         pop = 1;
         if (verbatim && (alpha(c) || (c >= "0" && c <= "9") || c == CH_DASH)) begin
            step_bytes.push_back(c);
         end else begin
            verbatim = 1'b0;
            if (kind_of(c) == CLS_VOWEL) begin
               emit_cp(GLYPH[c - LETTER_BASE]);
            end else if (kind_of(c) == CLS_NONE) begin
               step_bytes.push_back(c);
               if (c == CH_AT) verbatim = 1'b1;
            end else begin
               g = GLYPH[c - LETTER_BASE];
               if (cnt < 2 && !fin) break;
               n1 = cnt >= 2 ? w[1] : 8'h00;
               if (cnt < 2 || kind_of(n1) != CLS_VOWEL) begin
                  emit_cp(g);
                  emit_cp(CP_HALANT);
               end else if (n1 == CH_A) begin
                  emit_cp(g);
                  pop = 2;
               end else if (n1 == CH_NUKTA || n1 == CH_O) begin
                  if (cnt < 3 && !fin) break;
                  n2 = cnt >= 3 ? w[2] : 8'h00;
                  emit_cp(g);
                  if (n1 == CH_NUKTA) begin
                     emit_cp(CP_NUKTA);
                     if (cnt >= 3 && kind_of(n2) == CLS_VOWEL) begin
                        if (n2 != CH_A) emit_cp(VSIGN[n2 - LETTER_BASE]);
                        pop = 3;
                     end else begin
                        emit_cp(CP_HALANT);
                        pop = 2;
                     end
                  end else if (cnt >= 3 && n2 == CH_Y) begin
                     emit_cp(CP_CANDRA_O);
                     pop = 3;
                  end else begin
                     emit_cp(VSIGN[n1 - LETTER_BASE]);
                     pop = 2;
                  end
               end else begin
                  emit_cp(g);
                  emit_cp(VSIGN[n1 - LETTER_BASE]);
                  pop = 2;
               end
            end
         end
         for (int k = 0; k + pop < cnt; k++) w[k] = w[k + pop];
         cnt -= pop;
      end
      if (fin) begin
         cnt = 0;
         verbatim = 1'b0;
      end
      window_fill = cnt;
      window[0] = cnt > 0 ? w[0] : 8'h00;
      window[1] = cnt > 1 ? w[1] : 8'h00;
      foreach (step_bytes[k]) begin
         e.data = step_bytes[k];
         e.last = (k == step_bytes.size() - 1);
         e.text_end = e.last && fin;
         expected_bytes.push_back(e);
      end
   endtask

   task automatic note_failure(input string what, input utf8_byte_type exp_b);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t mismatch (%s): expected byte=%h last=%b end=%b,",
                  $time, what, exp_b.data, exp_b.last, exp_b.text_end,
                  " got byte=%h last=%b end=%b",
                  rsp_out_byte, rsp_out_last, rsp_out_text_end);
   endtask

   initial begin
      fail_count = 0;
      bytes_owed = 0;
   end

   always @(posedge clock) begin
      utf8_byte_type e;
      if (reset) begin
         expected_bytes.delete();
         window_fill = 0;
         verbatim = 1'b0;
         window[0] = 8'h00;
         window[1] = 8'h00;
      end else begin
         // a result can never come from the transaction accepted at the same edge
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               e = '{8'h00, 1'b0, 1'b0};
               note_failure("unexpected", e);
            end else begin
               e = expected_bytes.pop_front();
               if (e.data !== rsp_out_byte || e.last !== rsp_out_last ||
                   e.text_end !== rsp_out_text_end)
                  note_failure("field", e);
            end
         end
         if (req_valid && req_ready) convert_byte(req_in_byte, req_in_last);
      end
      bytes_owed = expected_bytes.size();
   end

endmodule

// ===== test/tb.sv =====
// Testbench top: drives WX text into the converter and reports the verdict.
`timescale 1ns / 1ps
module tb;
   import wxdev_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_in_last = 1'b0;
   logic       rsp_ready = 1'b0;
   logic       req_ready, rsp_valid, rsp_out_last, rsp_out_text_end;
   logic [7:0] rsp_out_byte;
   int         fail_count, bytes_owed;
   int         idle_pct = 0;
   int         stall_pct = 0;
   int         cycles = 0;
   int         sent = 0;

   // WX letters and the bytes that shape the lookahead
   string text_pool = "kKgGfcCjJFtTdDNwWxXnpPbBmyrlvSsRhaAiIuUqQeEoOMHzZZooYYLV@@-09 .";

   wx_to_devanagari_utf8 dut (
      .clock, .reset, .req_valid, .req_ready, .req_in_byte, .req_in_last,
      .rsp_valid, .rsp_ready, .rsp_out_byte, .rsp_out_last, .rsp_out_text_end
   );

   wx_to_devanagari_utf8_checker checker_i (
      .clock, .reset, .req_valid, .req_ready, .req_in_byte, .req_in_last,
      .rsp_valid, .rsp_ready, .rsp_out_byte, .rsp_out_last, .rsp_out_text_end,
      .fail_count, .bytes_owed
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (!reset) rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_byte(input logic [7:0] b, input logic fin);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_in_last <= fin;
      do @(posedge clock); while (!req_ready);
      sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
   endtask

   task automatic random_text();
      int len;
      logic fin;
      len = $urandom_range(10, 1);
      for (int i = 0; i < len; i++) begin
         fin = (i == len - 1) && ($urandom_range(9) != 0);
         if ($urandom_range(4) == 0) send_byte(8'($urandom_range(255)), fin);
         else send_byte(text_pool[$urandom_range(text_pool.len() - 1)], fin);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_text("kakIkZi");
      send_text("kZakoYko");
      send_text("kZ");
      send_text("k");
      send_text("Z");
      send_text("LVY");
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_text("k.@aZ-9 k");

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 46; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 46; end
            default: begin idle_pct = 10; stall_pct = 10; end
         endcase
         while (sent < 25 + (phase + 1) * 110) random_text();
      end
      send_byte("a", 1'b1);
      req_valid <= 1'b0;

      while (bytes_owed != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (fail_count == 0 && bytes_owed == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
